### rtl/core/ypcb_pkg.sv
// ----------------------------------------------------------------------------
// ypcb_pkg
// Shared types, constants and tables for the yaw/pitch camera basis block.
// ----------------------------------------------------------------------------
package ypcb_pkg;

	// CORDIC iteration count; the arctangent table covers up to 24 steps
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = 5;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

	// angles in 1/1024 degree
	localparam int ANG_W  = 19;
	localparam int ANGX_W = ANG_W + 1;
	localparam logic [ANG_W-1:0] YAW_RESET = 19'd276480;
	localparam logic signed [ANGX_W-1:0] FULL_TURN    = 20'sd368640;
	localparam logic signed [ANGX_W-1:0] HALF_TURN    = 20'sd184320;
	localparam logic signed [ANGX_W-1:0] QUARTER_TURN = 20'sd92160;
	localparam logic signed [31:0]       PITCH_LIMIT  = 32'sd91136;

	// CORDIC datapath: x, y in Q1.30 with headroom, z in 2^-20 degree
	localparam int XY_W = 33;
	localparam int Z_W  = 30;
	localparam int AT_W = 27;
	localparam logic signed [XY_W-1:0] GAIN_Q30 = 33'sd652032874;

	localparam int D_W = 16;
	localparam logic signed [D_W-1:0] Q14_ONE = 16'sd16384;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ANG,
		ST_MOD,
		ST_YAW,
		ST_PITCH,
		ST_MUL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [ANG_W-1:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic                  done;
		logic signed [D_W-1:0] sin_v;
		logic signed [D_W-1:0] cos_v;
	} cordic_res_t;

	// atan(2^-i) in 2^-20 degree
	function automatic logic [AT_W-1:0] cordic_atan(input logic [STEP_W-1:0] idx);
		logic [AT_W-1:0] v;
		case (idx)
			5'd0:    v = 27'd47185920;
			5'd1:    v = 27'd27855475;
			5'd2:    v = 27'd14718068;
			5'd3:    v = 27'd7471121;
			5'd4:    v = 27'd3750058;
			5'd5:    v = 27'd1876857;
			5'd6:    v = 27'd938658;
			5'd7:    v = 27'd469357;
			5'd8:    v = 27'd234682;
			5'd9:    v = 27'd117342;
			5'd10:   v = 27'd58671;
			5'd11:   v = 27'd29335;
			5'd12:   v = 27'd14668;
			5'd13:   v = 27'd7334;
			5'd14:   v = 27'd3667;
			5'd15:   v = 27'd1833;
			5'd16:   v = 27'd917;
			5'd17:   v = 27'd458;
			5'd18:   v = 27'd229;
			5'd19:   v = 27'd115;
			5'd20:   v = 27'd57;
			5'd21:   v = 27'd29;
			5'd22:   v = 27'd14;
			5'd23:   v = 27'd7;
			default: v = '0;
		endcase
		return v;
	endfunction

	// limit to plus or minus one in Q1.14
	function automatic logic signed [D_W-1:0] lim_q14(input logic signed [17:0] v);
		logic signed [D_W-1:0] r;
		if (v > 18'sd16384) begin
			r = Q14_ONE;
		end else if (v < -18'sd16384) begin
			r = -Q14_ONE;
		end else begin
			r = v[D_W-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/core/ypcb_cordic.sv
// ----------------------------------------------------------------------------
// ypcb_cordic
// Rotation-mode CORDIC, one iteration per cycle; sine and cosine in Q1.14.
// ----------------------------------------------------------------------------
module ypcb_cordic (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ypcb_pkg::cordic_req_t req,
	output ypcb_pkg::cordic_res_t res
);
	import ypcb_pkg::*;

	logic                     run_q, fin_q, done_q, neg_q;
	logic [STEP_W-1:0]        cnt_q;
	logic signed [XY_W-1:0]   x_q, y_q;
	logic signed [Z_W-1:0]    z_q;
	logic signed [D_W-1:0]    sin_q, cos_q;

	// range reduction to [-90, 90] degrees
	logic signed [ANGX_W-1:0] a1, a2;
	logic                     fold;
	logic signed [XY_W-1:0]   xs, ys;
	logic signed [Z_W-1:0]    at;
	logic signed [XY_W-1:0]   xr, yr;
	logic signed [D_W-1:0]    cl;

	always_comb begin
		a1 = $signed({1'b0, req.angle});
		if (a1 >= HALF_TURN) begin
			a1 = a1 - FULL_TURN;
		end
		fold = 1'b1;
		if (a1 > QUARTER_TURN) begin
			a2 = HALF_TURN - a1;
		end else if (a1 < -QUARTER_TURN) begin
			a2 = -HALF_TURN - a1;
		end else begin
			a2   = a1;
			fold = 1'b0;
		end
	end

	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign at = $signed({{(Z_W-AT_W){1'b0}}, cordic_atan(cnt_q)});

	// round away the low 16 bits (floor after adding one half)
	assign xr = x_q + 33'sd32768;
	assign yr = y_q + 33'sd32768;
	assign cl = lim_q14({xr[XY_W-1], xr[XY_W-1:16]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= fin_q;
			fin_q  <= run_q && (cnt_q == STEP_LAST);
			if (req.start && !run_q && !fin_q) begin
				run_q <= 1'b1;
			end else if (run_q && (cnt_q == STEP_LAST)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !run_q && !fin_q) begin
			x_q   <= GAIN_Q30;
			y_q   <= '0;
			z_q   <= {{(Z_W-ANGX_W){a2[ANGX_W-1]}}, a2} <<< 10;
			neg_q <= fold;
			cnt_q <= '0;
		end else if (run_q) begin
			if (!z_q[Z_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
			cnt_q <= cnt_q + 1'b1;
		end
		if (fin_q) begin
			sin_q <= lim_q14({yr[XY_W-1], yr[XY_W-1:16]});
			cos_q <= neg_q ? -cl : cl;
		end
	end

	assign res.done  = done_q;
	assign res.sin_v = sin_q;
	assign res.cos_v = cos_q;

endmodule

### rtl/core/yaw_pitch_camera_basis.sv
// ----------------------------------------------------------------------------
// yaw_pitch_camera_basis
// Yaw/pitch camera: accumulates pointer movement, returns forward/right/up.
// ----------------------------------------------------------------------------
// Each input item is one pointer movement. Both offsets are divided by four
// (floor) and added to the stored yaw and pitch, kept in 1/1024 degree. Yaw
// wraps over a full turn; pitch saturates at the signed 32-bit range and, when
// clamp_pitch is set, at plus or minus 89 degrees. Reset puts yaw at 270
// degrees and pitch at zero. One result item follows each input item: the
// forward, right and up vectors in Q1.14 (right y is always zero and is not
// sent). Right is negated when cos(pitch) is negative; when it is exactly zero
// the plain form is used. Each item runs the single CORDIC unit once for yaw
// and once for pitch, one iteration a cycle, followed by four passes through
// one 16x16 multiplier. s_tready is low from acceptance until the result is
// loaded into the output register and comes back in the cycle after, so a new
// item is only taken once the previous one is through. The result sits in an
// output register, so the next item is taken while an earlier result still
// waits on m_tready; only a result that is finished while the previous one is
// still held waits.
// ----------------------------------------------------------------------------
module yaw_pitch_camera_basis (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [15:0] yaw_offset, [31:16] pitch_offset, [32] clamp_pitch, [39:33] zero
	input  logic [39:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [15:0] fwd_x, [31:16] fwd_y, [47:32] fwd_z, [63:48] right_x,
	// [79:64] right_z, [95:80] up_x, [111:96] up_y, [127:112] up_z
	output logic [127:0] m_tdata
);
	import ypcb_pkg::*;

	state_t state_q, state_d;

	// accepted item: offsets already divided by four
	logic signed [13:0]       dy_q, dp_q;
	logic                     clamp_q;

	// camera state; pmod_q follows pitch modulo a full turn
	logic [ANG_W-1:0]         yaw_q, pmod_q;
	logic signed [31:0]       pitch_q;
	logic signed [14:0]       dlt_q;

	// sines and cosines, and the four rounded products
	logic signed [D_W-1:0]    sy_q, cy_q, sp_q, cp_q;
	logic signed [D_W-1:0]    prd_q [4];
	logic [1:0]               mcnt_q;

	cordic_req_t              creq;
	cordic_res_t              cres;

	logic                     accept, out_load;

	ypcb_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.res    (cres)
	);

	assign accept = s_tvalid && s_tready;

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		creq.start = 1'b0;
		creq.angle = yaw_q;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_ANG;
				end
			end
			ST_ANG: begin
				state_d = ST_MOD;
			end
			ST_MOD: begin
				// yaw is already updated here
				creq.start = 1'b1;
				state_d    = ST_YAW;
			end
			ST_YAW: begin
				creq.angle = pmod_q;
				if (cres.done) begin
					creq.start = 1'b1;
					state_d    = ST_PITCH;
				end
			end
			ST_PITCH: begin
				if (cres.done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mcnt_q == 2'd3) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// wait for the output register to be free
				if (!m_tvalid || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---- angle update ----
	// one wrapping adder, yaw in ST_ANG and the pitch residue in ST_MOD
	logic [ANG_W-1:0]         wa, wrapped;
	logic signed [14:0]       wb;
	logic signed [ANGX_W-1:0] wsum;

	assign wa = (state_q == ST_ANG) ? yaw_q : pmod_q;
	assign wb = (state_q == ST_ANG) ? {dy_q[13], dy_q} : dlt_q;

	always_comb begin
		wsum = $signed({1'b0, wa}) + {{(ANGX_W-15){wb[14]}}, wb};
		if (wsum < 0) begin
			wsum = wsum + FULL_TURN;
		end else if (wsum >= FULL_TURN) begin
			wsum = wsum - FULL_TURN;
		end
		wrapped = wsum[ANG_W-1:0];
	end

	// pitch: saturating add, then the optional 89 degree clamp
	logic signed [32:0]       psum, pdiff;
	logic signed [31:0]       psat, pnew;

	always_comb begin
		psum = {pitch_q[31], pitch_q} + {{19{dp_q[13]}}, dp_q};
		if (psum[32] != psum[31]) begin
			psat = psum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
		end else begin
			psat = psum[31:0];
		end
		pnew = psat;
		if (clamp_q && (psat > PITCH_LIMIT)) begin
			pnew = PITCH_LIMIT;
		end else if (clamp_q && (psat < -PITCH_LIMIT)) begin
			pnew = -PITCH_LIMIT;
		end
		// unclamped, the step actually taken is always within one offset
		pdiff = {pnew[31], pnew} - {pitch_q[31], pitch_q};
	end

	// clamped, pitch may jump from far away but lies within 89 degrees,
	// so its residue comes straight from the new pitch
	logic signed [31:0]       pwrap;
	logic [ANG_W-1:0]         pclamp;

	assign pwrap  = pitch_q + 32'(FULL_TURN);
	assign pclamp = pitch_q[31] ? pwrap[ANG_W-1:0] : pitch_q[ANG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q   <= YAW_RESET;
			pitch_q <= '0;
			pmod_q  <= '0;
		end else begin
			if (state_q == ST_ANG) begin
				yaw_q   <= wrapped;
				pitch_q <= pnew;
			end
			if (state_q == ST_MOD) begin
				pmod_q <= clamp_q ? pclamp : wrapped;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dy_q    <= $signed(s_tdata[15:2]);
			dp_q    <= $signed(s_tdata[31:18]);
			clamp_q <= s_tdata[32];
		end
		if (state_q == ST_ANG) begin
			dlt_q <= pdiff[14:0];
		end
	end

	// ---- products ----
	// order: cy*cp, sy*cp, cy*sp, sy*sp; the last two carry the sign of -s
	logic signed [D_W-1:0]    ma, mb;
	logic signed [31:0]       prod, sprod, rsum;
	logic                     s_neg;

	assign s_neg = cp_q[D_W-1];
	assign ma    = mcnt_q[0] ? sy_q : cy_q;
	assign mb    = mcnt_q[1] ? sp_q : cp_q;
	assign prod  = ma * mb;
	assign sprod = (mcnt_q[1] && !s_neg) ? -prod : prod;
	assign rsum  = sprod + 32'sd8192;

	always_ff @(posedge clk) begin
		if (state_q == ST_YAW && cres.done) begin
			sy_q <= cres.sin_v;
			cy_q <= cres.cos_v;
		end
		if (state_q == ST_PITCH && cres.done) begin
			sp_q <= cres.sin_v;
			cp_q <= cres.cos_v;
		end
		if (state_q == ST_MUL) begin
			prd_q[mcnt_q] <= lim_q14(rsum[31:14]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
		end else if (state_q == ST_MUL) begin
			mcnt_q <= mcnt_q + 1'b1;
		end else begin
			mcnt_q <= '0;
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {prd_q[3],
			            s_neg ? -cp_q : cp_q,
			            prd_q[2],
			            s_neg ? -cy_q : cy_q,
			            s_neg ? sy_q : -sy_q,
			            prd_q[1],
			            sp_q,
			            prd_q[0]};
		end
	end

endmodule

### rtl/core/ypcb_checker.sv
// ----------------------------------------------------------------------------
// ypcb_checker
// Port-level checks for the camera basis block, bound to the top level.
// ----------------------------------------------------------------------------
module ypcb_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata
);

	// an accepted item keeps the block busy for several cycles
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready ##1 !s_tready ##1 !s_tready)
		else $error("input taken again too soon after an item");

	// a new result only appears at the end of a busy period
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result item without preceding work");

	// up y is |cos pitch| and never negative
	a_up_y_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[111])
		else $error("up_y negative");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result item changed while stalled");

endmodule

bind yaw_pitch_camera_basis ypcb_checker u_ypcb_checker (.*);
